>>> rtl/mmix_pkg.sv
// Shared types, constants, microprogram and pulse saturation helpers of the motor mixer.
`timescale 1ns / 1ps
package mmix_pkg;

  localparam int unsigned MOTORS_DEF = 6;
  localparam int unsigned FRAC_DEF   = 13;
  localparam int unsigned AXES       = 3;

  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned CORR_W     = 16;
  localparam int unsigned PROD_W     = WEIGHT_W + CORR_W;
  localparam int unsigned ACC_W      = PROD_W + 2;
  localparam int unsigned SUM_W      = ACC_W + 1;
  localparam int unsigned MOTOR_W    = 3;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned IDX_CALC_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PC_W       = 5;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_ARM = 2'd2;

  localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2000;
  localparam logic [PULSE_W-1:0] PULSE_ARM_RST = 12'd900;

  localparam logic [ACTION_W-1:0] ACT_MODE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COEF  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MIX   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CAL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ARMING = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ARMED  = 2'd3;

  localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;

  // Microprogram addresses.
  localparam logic [PC_W-1:0] STEP_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] STEP_DISPATCH = 5'd1;
  localparam logic [PC_W-1:0] STEP_JT_MODE  = 5'd2;
  localparam logic [PC_W-1:0] STEP_JT_COEF  = 5'd3;
  localparam logic [PC_W-1:0] STEP_JT_MIX   = 5'd4;
  localparam logic [PC_W-1:0] STEP_JT_NONE  = 5'd5;
  localparam logic [PC_W-1:0] STEP_MODE     = 5'd6;
  localparam logic [PC_W-1:0] STEP_MODE_OUT = 5'd7;
  localparam logic [PC_W-1:0] STEP_MODE_END = 5'd8;
  localparam logic [PC_W-1:0] STEP_MIX      = 5'd9;
  localparam logic [PC_W-1:0] STEP_MUL_P    = 5'd10;
  localparam logic [PC_W-1:0] STEP_MUL_R    = 5'd11;
  localparam logic [PC_W-1:0] STEP_MUL_Y    = 5'd12;
  localparam logic [PC_W-1:0] STEP_ACC_END  = 5'd13;
  localparam logic [PC_W-1:0] STEP_SUM      = 5'd14;
  localparam logic [PC_W-1:0] STEP_MIX_OUT  = 5'd15;
  localparam logic [PC_W-1:0] STEP_MIX_END  = 5'd16;
  localparam logic [PC_W-1:0] STEP_LAST     = STEP_MIX_END;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_BEAT,
    COND_SAME_MODE,
    COND_NOT_ARMED,
    COND_MORE_MOTORS,
    COND_DISPATCH
  } cond_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_e;

  typedef enum logic {
    SRC_MODE,
    SRC_MIX
  } src_e;

  typedef struct packed {
    cond_e             cond;
    logic [PC_W-1:0]   target;
    logic              in_ready;
    logic              mode_wr;
    logic              wt_wr;
    logic              motor_clr;
    logic              motor_inc;
    logic              mul_en;
    logic [AXIS_W-1:0] mul_axis;
    acc_e              acc_op;
    logic              sum_en;
    logic              out_load;
    src_e              out_src;
  } ctrl_t;

  typedef struct packed {
    logic                beat;
    logic                same_mode;
    logic                armed;
    logic                more_motors;
    logic                slot_free;
    logic [ACTION_W-1:0] action;
  } stat_t;

  function automatic ctrl_t useq_word(logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_NO_BEAT;
        w.target   = STEP_IDLE;
      end
      STEP_DISPATCH: begin
        w.cond   = COND_DISPATCH;
        w.target = STEP_JT_MODE;
      end
      STEP_JT_MODE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_MODE;
      end
      STEP_JT_COEF: begin
        w.wt_wr  = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      STEP_JT_MIX: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_MIX;
      end
      STEP_JT_NONE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      STEP_MODE: begin
        w.mode_wr   = 1'b1;
        w.motor_clr = 1'b1;
        w.cond      = COND_SAME_MODE;
        w.target    = STEP_IDLE;
      end
      STEP_MODE_OUT: begin
        w.out_load  = 1'b1;
        w.out_src   = SRC_MODE;
        w.motor_inc = 1'b1;
        w.cond      = COND_MORE_MOTORS;
        w.target    = STEP_MODE_OUT;
      end
      STEP_MODE_END: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      STEP_MIX: begin
        w.motor_clr = 1'b1;
        w.cond      = COND_NOT_ARMED;
        w.target    = STEP_IDLE;
      end
      STEP_MUL_P: begin
        w.mul_en   = 1'b1;
        w.mul_axis = AXIS_PITCH;
      end
      STEP_MUL_R: begin
        w.mul_en   = 1'b1;
        w.mul_axis = AXIS_ROLL;
        w.acc_op   = ACC_LOAD;
      end
      STEP_MUL_Y: begin
        w.mul_en   = 1'b1;
        w.mul_axis = AXIS_YAW;
        w.acc_op   = ACC_ADD;
      end
      STEP_ACC_END: begin
        w.acc_op = ACC_ADD;
      end
      STEP_SUM: begin
        w.sum_en = 1'b1;
      end
      STEP_MIX_OUT: begin
        w.out_load  = 1'b1;
        w.out_src   = SRC_MIX;
        w.motor_inc = 1'b1;
        w.cond      = COND_MORE_MOTORS;
        w.target    = STEP_MUL_P;
      end
      STEP_MIX_END: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Clamp a signed value to lo..hi, testing the low bound first.
  function automatic logic [PULSE_W-1:0] sat_pulse(logic signed [SUM_W-1:0] x,
                                                   logic [PULSE_W-1:0] lo,
                                                   logic [PULSE_W-1:0] hi);
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    logic [PULSE_W-1:0]      r;
    lo_s = $signed({{(SUM_W-PULSE_W){1'b0}}, lo});
    hi_s = $signed({{(SUM_W-PULSE_W){1'b0}}, hi});
    if (x < lo_s) begin
      r = lo;
    end else if (x > hi_s) begin
      r = hi;
    end else begin
      r = x[PULSE_W-1:0];
    end
    return r;
  endfunction

  // A pulse that is neither zero nor the arming pulse is clamped once more.
  function automatic logic [PULSE_W-1:0] final_pulse(logic [PULSE_W-1:0] p,
                                                     logic [PULSE_W-1:0] lo,
                                                     logic [PULSE_W-1:0] hi,
                                                     logic [PULSE_W-1:0] arm);
    logic [PULSE_W-1:0] r;
    if (p != '0 && p != arm) begin
      r = sat_pulse($signed({{(SUM_W-PULSE_W){1'b0}}, p}), lo, hi);
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

>>> rtl/mmix_useq.sv
// Microcode sequencer of the motor mixer: step counter, control store and jump logic.
`timescale 1ns / 1ps
module mmix_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mmix_pkg::stat_t stat_i,
  output mmix_pkg::ctrl_t ctrl_o
);
  import mmix_pkg::*;

  logic [PC_W-1:0] pc_q;
  logic [PC_W-1:0] pc_d;
  ctrl_t           word;
  logic            stall;
  logic            take;

  assign word  = useq_word(pc_q);
  assign stall = word.out_load && !stat_i.slot_free;

  // A stalled step repeats with its side effects held back.
  always_comb begin
    ctrl_o = word;
    if (stall) begin
      ctrl_o.out_load  = 1'b0;
      ctrl_o.motor_inc = 1'b0;
    end
  end

  always_comb begin
    case (word.cond)
      COND_NEXT:        take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_BEAT:     take = !stat_i.beat;
      COND_SAME_MODE:   take = stat_i.same_mode;
      COND_NOT_ARMED:   take = !stat_i.armed;
      COND_MORE_MOTORS: take = stat_i.more_motors;
      COND_DISPATCH:    take = 1'b1;
      default:          take = 1'b1;
    endcase
    if (stall) begin
      pc_d = pc_q;
    end else if (word.cond == COND_DISPATCH) begin
      pc_d = word.target + PC_W'(stat_i.action);
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= STEP_LAST)
    else $error("step counter left the control store");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> pc_q == $past(pc_q))
    else $error("step advanced during an output stall");

  a_beat_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.beat |=> pc_q == STEP_DISPATCH)
    else $error("accepted beat not followed by dispatch");

endmodule

>>> rtl/mmix_datapath.sv
// Datapath of the motor mixer: item capture, weight table, multiply-accumulate, saturation.
`timescale 1ns / 1ps
module mmix_datapath #(
  parameter int unsigned Motors         = mmix_pkg::MOTORS_DEF,
  parameter int unsigned WeightFracBits = mmix_pkg::FRAC_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mmix_pkg::ctrl_t                      ctrl_i,
  output mmix_pkg::stat_t                      stat_o,
  input  logic                                 cfg_we_i,
  input  logic [mmix_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mmix_pkg::PULSE_W-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic [mmix_pkg::ACTION_W-1:0]        action_i,
  input  logic [mmix_pkg::MODE_W-1:0]          new_mode_i,
  input  logic [mmix_pkg::MOTOR_W-1:0]         motor_index_i,
  input  logic [mmix_pkg::AXIS_W-1:0]          axis_index_i,
  input  logic signed [mmix_pkg::WEIGHT_W-1:0] coefficient_i,
  input  logic [mmix_pkg::THR_W-1:0]           throttle_i,
  input  logic signed [mmix_pkg::CORR_W-1:0]   pitch_correction_i,
  input  logic signed [mmix_pkg::CORR_W-1:0]   roll_correction_i,
  input  logic signed [mmix_pkg::CORR_W-1:0]   yaw_correction_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [mmix_pkg::MOTOR_W-1:0]         motor_number_o,
  output logic [mmix_pkg::PULSE_W-1:0]         pulse_width_o,
  output logic                                 outputs_enabled_o,
  output logic                                 last_o
);
  import mmix_pkg::*;

  localparam int unsigned WtDepth = Motors * AXES;
  localparam int unsigned WtIdxW  = $clog2(WtDepth);

  logic [PULSE_W-1:0] pulse_min_q;
  logic [PULSE_W-1:0] pulse_max_q;
  logic [PULSE_W-1:0] pulse_arm_q;

  logic [ACTION_W-1:0]        action_q;
  logic [MODE_W-1:0]          new_mode_q;
  logic [MOTOR_W-1:0]         motor_index_q;
  logic [AXIS_W-1:0]          axis_index_q;
  logic signed [WEIGHT_W-1:0] coefficient_q;
  logic [THR_W-1:0]           throttle_q;
  logic signed [CORR_W-1:0]   pitch_q;
  logic signed [CORR_W-1:0]   roll_q;
  logic signed [CORR_W-1:0]   yaw_q;

  logic [MODE_W-1:0]          mode_q;
  logic signed [WEIGHT_W-1:0] wt_q [WtDepth];
  logic [MOTOR_W-1:0]         motor_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [PULSE_W-1:0]         mix_q;

  logic                 out_valid_q;
  logic [MOTOR_W-1:0]   out_motor_q;
  logic [PULSE_W-1:0]   out_pulse_q;
  logic                 out_en_q;
  logic                 out_last_q;

  logic                       beat;
  logic                       slot_free;
  logic                       more_motors;
  logic [IDX_CALC_W-1:0]      rd_full;
  logic [IDX_CALC_W-1:0]      wr_full;
  logic                       wr_ok;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [CORR_W-1:0]   corr;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [SUM_W-1:0]    sum;
  logic [PULSE_W-1:0]         mode_pulse;
  logic [PULSE_W-1:0]         raw_pulse;

  assign beat        = in_valid_i && ctrl_i.in_ready;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign more_motors = motor_q != MOTOR_W'(Motors - 1);

  assign stat_o.beat        = beat;
  assign stat_o.same_mode   = new_mode_q == mode_q;
  assign stat_o.armed       = mode_q == MODE_ARMED;
  assign stat_o.more_motors = more_motors;
  assign stat_o.slot_free   = slot_free;
  assign stat_o.action      = action_q;

  assign rd_full = IDX_CALC_W'(motor_q) * IDX_CALC_W'(AXES) + IDX_CALC_W'(ctrl_i.mul_axis);
  assign wr_full = IDX_CALC_W'(motor_index_q) * IDX_CALC_W'(AXES)
                 + IDX_CALC_W'(axis_index_q);
  assign wr_ok   = ({1'b0, motor_index_q} < (MOTOR_W + 1)'(Motors))
                && (IDX_CALC_W'(axis_index_q) < IDX_CALC_W'(AXES));
  assign weight  = wt_q[rd_full[WtIdxW-1:0]];

  always_comb begin
    case (ctrl_i.mul_axis)
      AXIS_PITCH: corr = pitch_q;
      AXIS_ROLL:  corr = roll_q;
      default:    corr = yaw_q;
    endcase
  end

  assign shifted = acc_q >>> WeightFracBits;
  assign sum     = $signed({{(SUM_W-THR_W){1'b0}}, throttle_q})
                 + $signed({shifted[ACC_W-1], shifted});

  always_comb begin
    case (new_mode_q)
      MODE_ARMING: mode_pulse = pulse_arm_q;
      MODE_ARMED:  mode_pulse = pulse_min_q;
      default:     mode_pulse = '0;
    endcase
  end

  assign raw_pulse = (ctrl_i.out_src == SRC_MIX) ? mix_q : mode_pulse;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_min_q <= PULSE_MIN_RST;
      pulse_max_q <= PULSE_MAX_RST;
      pulse_arm_q <= PULSE_ARM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PULSE_MIN: pulse_min_q <= cfg_data_i;
        CFG_PULSE_MAX: pulse_max_q <= cfg_data_i;
        CFG_PULSE_ARM: pulse_arm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) begin
      action_q      <= action_i;
      new_mode_q    <= new_mode_i;
      motor_index_q <= motor_index_i;
      axis_index_q  <= axis_index_i;
      coefficient_q <= coefficient_i;
      throttle_q    <= throttle_i;
      pitch_q       <= pitch_correction_i;
      roll_q        <= roll_correction_i;
      yaw_q         <= yaw_correction_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= weight * corr;
    end
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_q <= $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
      ACC_ADD:  acc_q <= acc_q + $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
      default:  ;
    endcase
    if (ctrl_i.sum_en) begin
      mix_q <= sat_pulse(sum, pulse_min_q, pulse_max_q);
    end
    if (ctrl_i.out_load) begin
      out_motor_q <= motor_q;
      out_pulse_q <= final_pulse(raw_pulse, pulse_min_q, pulse_max_q, pulse_arm_q);
      out_en_q    <= (mode_q == MODE_ARMING) || (mode_q == MODE_ARMED);
      out_last_q  <= !more_motors;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      motor_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WtDepth; i++) begin
        wt_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.mode_wr && new_mode_q != mode_q) begin
        mode_q <= new_mode_q;
      end
      if (ctrl_i.wt_wr && wr_ok) begin
        wt_q[wr_full[WtIdxW-1:0]] <= coefficient_q;
      end
      if (ctrl_i.motor_clr) begin
        motor_q <= '0;
      end else if (ctrl_i.motor_inc && more_motors) begin
        motor_q <= motor_q + MOTOR_W'(1);
      end
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motor_number_o    = out_motor_q;
  assign pulse_width_o     = out_pulse_q;
  assign outputs_enabled_o = out_en_q;
  assign last_o            = out_last_q;

  a_motor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    motor_q <= MOTOR_W'(Motors - 1))
    else $error("motor counter beyond the last motor");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> slot_free)
    else $error("output register overwritten while full");

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.mode_wr |=> mode_q == $past(new_mode_q))
    else $error("mode register missed a mode change");

endmodule

>>> rtl/multirotor_motor_mixer.sv
// Top level of the motor mixer: stream ports, configuration port, sequencer and datapath.
// A mode change beat gives its results one per cycle while the output is taken, and the
// block returns to idle, ready again, after the last one. A mix update runs per motor
// through three multiplies on one multiplier, accumulate, sum and load. A coefficient write,
// an unused action, a repeated mode and a mix while not armed return to idle without output.
// Reset clears the mode to idle, the weight table to zero and loads the default pulse limits;
// no clearing pass follows.
`timescale 1ns / 1ps
module multirotor_motor_mixer #(
  parameter int unsigned Motors         = mmix_pkg::MOTORS_DEF,
  parameter int unsigned WeightFracBits = mmix_pkg::FRAC_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mmix_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mmix_pkg::PULSE_W-1:0]        cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // new_mode, motor_index, axis_index, coefficient, throttle, pitch, roll, yaw corrections
  input  logic [mmix_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action
  input  logic [mmix_pkg::ACTION_W-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // motor_number, pulse_width
  output logic [mmix_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // outputs_enabled
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);
  import mmix_pkg::*;

  ctrl_t              ctrl;
  stat_t              stat;
  logic [MOTOR_W-1:0] motor_number;
  logic [PULSE_W-1:0] pulse_width;

  mmix_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mmix_datapath #(
    .Motors         (Motors),
    .WeightFracBits (WeightFracBits)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (s_axis_tvalid),
    .action_i           (s_axis_tuser),
    .new_mode_i         (s_axis_tdata[1:0]),
    .motor_index_i      (s_axis_tdata[4:2]),
    .axis_index_i       (s_axis_tdata[6:5]),
    .coefficient_i      ($signed(s_axis_tdata[22:7])),
    .throttle_i         (s_axis_tdata[34:23]),
    .pitch_correction_i ($signed(s_axis_tdata[50:35])),
    .roll_correction_i  ($signed(s_axis_tdata[66:51])),
    .yaw_correction_i   ($signed(s_axis_tdata[82:67])),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .motor_number_o     (motor_number),
    .pulse_width_o      (pulse_width),
    .outputs_enabled_o  (m_axis_tuser),
    .last_o             (m_axis_tlast)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tdata  = {{(OUT_TDATA_W-PULSE_W-MOTOR_W){1'b0}}, pulse_width, motor_number};

endmodule

>>> dv/multirotor_motor_mixer_test.sv
// Self-checking testbench for the multirotor motor mixer with its own pulse predictor.
`timescale 1ns / 1ps
module multirotor_motor_mixer_test;
  import mmix_pkg::*;

  localparam int unsigned MOTORS = MOTORS_DEF;
  localparam int unsigned FRAC = FRAC_DEF;
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned STALL_PCT = 20;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [MODE_W-1:0] new_mode;
    logic [MOTOR_W-1:0] motor;
    logic [AXIS_W-1:0] axis;
    logic signed [WEIGHT_W-1:0] coef;
    logic [THR_W-1:0] throttle;
    logic signed [CORR_W-1:0] pitch;
    logic signed [CORR_W-1:0] roll;
    logic signed [CORR_W-1:0] yaw;
  } mix_cmd_t;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    logic [PULSE_W-1:0] width;
    logic enabled;
    logic last;
  } pulse_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [PULSE_W-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic [ACTION_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  multirotor_motor_mixer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  mix_cmd_t cmd_queue[$];
  pulse_t due_pulses[$];
  mix_cmd_t cur_cmd;
  logic in_beat;
  bit stall_on;
  int unsigned pushed_cnt;
  int unsigned accepted_cnt;
  int unsigned error_cnt;
  int unsigned quiet_cycles;

  logic [PULSE_W-1:0] lim_min = PULSE_MIN_RST;
  logic [PULSE_W-1:0] lim_max = PULSE_MAX_RST;
  logic [PULSE_W-1:0] lim_arm = PULSE_ARM_RST;
  logic [MODE_W-1:0] mode_now = MODE_IDLE;
  logic signed [WEIGHT_W-1:0] gains[MOTORS*AXES];

  always #4 clk_i = ~clk_i;

  function automatic logic [PULSE_W-1:0] clamp_width(longint x);
    if (x < longint'(lim_min)) return lim_min;
    if (x > longint'(lim_max)) return lim_max;
    return PULSE_W'(x);
  endfunction

  function automatic logic [PULSE_W-1:0] gate_pulse(logic [PULSE_W-1:0] p);
    if (p != '0 && p != lim_arm) return clamp_width(longint'(p));
    return p;
  endfunction

  task automatic expect_pulse(int k, logic [PULSE_W-1:0] p, logic en);
    pulse_t r;
    r.motor = MOTOR_W'(k);
    r.width = gate_pulse(p);
    r.enabled = en;
    r.last = (k == MOTORS - 1);
    due_pulses.push_back(r);
  endtask

  task automatic predict_pulses(mix_cmd_t c);
    longint acc;
    logic [PULSE_W-1:0] p;
    case (c.action)
      ACT_MODE: begin
        if (c.new_mode != mode_now) begin
          mode_now = c.new_mode;
          if (mode_now == MODE_ARMING) p = lim_arm;
          else if (mode_now == MODE_ARMED) p = lim_min;
          else p = '0;
          for (int k = 0; k < MOTORS; k++)
            expect_pulse(k, p, mode_now == MODE_ARMING || mode_now == MODE_ARMED);
        end
      end
      ACT_COEF: begin
        if (c.motor < MOTORS && c.axis < AXES) gains[c.motor * AXES + c.axis] = c.coef;
      end
      ACT_MIX: begin
        if (mode_now == MODE_ARMED) begin
          for (int k = 0; k < MOTORS; k++) begin
            acc = longint'(gains[k * AXES + AXIS_PITCH]) * longint'(c.pitch)
                + longint'(gains[k * AXES + AXIS_ROLL]) * longint'(c.roll)
                + longint'(gains[k * AXES + AXIS_YAW]) * longint'(c.yaw);
            acc = longint'(c.throttle) + (acc >>> FRAC);
            expect_pulse(k, clamp_width(acc), 1'b1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_error(string what, pulse_t want, pulse_t got);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) begin
      $display("%0t %s: expected motor %0d width %0d en %0b last %0b",
               $realtime, what, want.motor, want.width, want.enabled, want.last);
      $display("  got motor %0d width %0d en %0b last %0b",
               got.motor, got.width, got.enabled, got.last);
    end
  endtask

  // Sample both streams, check results and predict for each accepted input beat.
  always @(posedge clk_i) begin
    pulse_t got;
    pulse_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.motor = m_axis_tdata[MOTOR_W-1:0];
        got.width = m_axis_tdata[MOTOR_W+PULSE_W-1:MOTOR_W];
        got.enabled = m_axis_tuser;
        got.last = m_axis_tlast;
        if (due_pulses.size() == 0) begin
          note_error("unexpected beat", '0, got);
        end else begin
          want = due_pulses.pop_front();
          if (got != want) note_error("mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pulses(cur_cmd);
        accepted_cnt++;
      end
      in_beat <= s_axis_tvalid && s_axis_tready;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    mix_cmd_t c;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_beat) begin
        if (cmd_queue.size() > 0 && !(stall_on && $urandom_range(0, 99) < STALL_PCT)) begin
          c = cmd_queue.pop_front();
          cur_cmd <= c;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= c.action;
          s_axis_tdata <= {5'b0, c.yaw, c.roll, c.pitch, c.throttle, c.coef, c.axis,
                           c.motor, c.new_mode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !(stall_on && $urandom_range(0, 99) < STALL_PCT);
    end
  end

  function automatic mix_cmd_t rand_cmd();
    mix_cmd_t c;
    c.action = ACTION_W'($urandom);
    c.new_mode = MODE_W'($urandom);
    c.motor = MOTOR_W'($urandom);
    c.axis = AXIS_W'($urandom);
    c.coef = WEIGHT_W'($urandom);
    c.throttle = THR_W'($urandom);
    c.pitch = CORR_W'($urandom);
    c.roll = CORR_W'($urandom);
    c.yaw = CORR_W'($urandom);
    return c;
  endfunction

  function automatic logic [15:0] near_zero(int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v[15:0];
  endfunction

  function automatic mix_cmd_t make_cmd(logic [ACTION_W-1:0] act, logic [MODE_W-1:0] mode,
                                        logic [MOTOR_W-1:0] motor, logic [AXIS_W-1:0] axis,
                                        logic [15:0] coef, logic [THR_W-1:0] thr,
                                        logic [15:0] p, logic [15:0] r, logic [15:0] y);
    mix_cmd_t c;
    c.action = act;
    c.new_mode = mode;
    c.motor = motor;
    c.axis = axis;
    c.coef = coef;
    c.throttle = thr;
    c.pitch = p;
    c.roll = r;
    c.yaw = y;
    return c;
  endfunction

  task automatic send(mix_cmd_t c);
    cmd_queue.push_back(c);
    pushed_cnt++;
  endtask

  task automatic wait_drain();
    while (accepted_cnt != pushed_cnt || due_pulses.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PULSE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_PULSE_MIN: lim_min = val;
      CFG_PULSE_MAX: lim_max = val;
      CFG_PULSE_ARM: lim_arm = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Arm the motors, then mostly mix updates with some weight writes, mode changes and noise.
  task automatic run_phase(int n);
    mix_cmd_t c;
    int r;
    c = rand_cmd();
    c.action = ACT_MODE;
    c.new_mode = MODE_ARMING;
    send(c);
    c.new_mode = MODE_ARMED;
    send(c);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drain();
      c = rand_cmd();
      r = $urandom_range(0, 99);
      if (r < 7) begin
        c.action = ACT_MODE;
        send(c);
        if ($urandom_range(0, 99) < 60) begin
          c = rand_cmd();
          c.action = ACT_MODE;
          c.new_mode = MODE_ARMED;
          send(c);
        end
      end else if (r < 24) begin
        c.action = ACT_COEF;
        c.motor = ($urandom_range(0, 9) < 9) ? MOTOR_W'($urandom_range(0, MOTORS - 1))
                                             : MOTOR_W'($urandom_range(6, 7));
        c.axis = ($urandom_range(0, 9) < 9) ? AXIS_W'($urandom_range(0, AXES - 1)) : 2'd3;
        if ($urandom_range(0, 1)) c.coef = near_zero(12000);
        send(c);
      end else if (r < 94) begin
        c.action = ACT_MIX;
        if ($urandom_range(0, 1)) c.throttle = THR_W'($urandom_range(900, 2100));
        if ($urandom_range(0, 1)) begin
          c.pitch = near_zero(600);
          c.roll = near_zero(600);
          c.yaw = near_zero(600);
        end
        send(c);
      end else begin
        if ($urandom_range(0, 1)) c.action = ACT_NONE;
        else c.action = ACT_MIX;
        if (c.action == ACT_MIX) begin
          c.action = ACT_MODE;
          c.new_mode = MODE_IDLE;
          send(c);
          c = rand_cmd();
          c.action = ACT_MIX;
        end
        send(c);
      end
    end
    settle();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    in_beat = 1'b0;
    stall_on = 1'b1;
    quiet_cycles = 0;
    for (int i = 0; i < MOTORS * AXES; i++) gains[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset limits.
    send(make_cmd(ACT_MIX, MODE_IDLE, 3'd0, 2'd0, 16'h0000, 12'd1500, 16'h0100, 16'h0100,
                  16'h0100));
    send(make_cmd(ACT_MODE, MODE_IDLE, 3'd0, 2'd0, 16'h0000, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_NONE, MODE_ARMED, 3'd7, 2'd3, 16'hffff, 12'hfff, 16'hffff, 16'hffff,
                  16'hffff));
    send(make_cmd(ACT_COEF, MODE_IDLE, 3'd6, AXIS_PITCH, 16'h1234, 12'd0, 16'h0, 16'h0,
                  16'h0));
    send(make_cmd(ACT_COEF, MODE_IDLE, 3'd0, 2'd3, 16'h4321, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_COEF, MODE_IDLE, 3'd7, 2'd3, 16'h7fff, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_COEF, MODE_IDLE, 3'd0, AXIS_PITCH, 16'h8000, 12'd0, 16'h0, 16'h0,
                  16'h0));
    send(make_cmd(ACT_COEF, MODE_IDLE, 3'd1, AXIS_ROLL, 16'h7fff, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_COEF, MODE_IDLE, 3'd5, AXIS_YAW, 16'h2000, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_COEF, MODE_IDLE, 3'd2, AXIS_PITCH, 16'h2000, 12'd0, 16'h0, 16'h0,
                  16'h0));
    send(make_cmd(ACT_COEF, MODE_IDLE, 3'd3, AXIS_ROLL, 16'he000, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_COEF, MODE_IDLE, 3'd4, AXIS_YAW, 16'hffff, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_MODE, MODE_CAL, 3'd0, 2'd0, 16'h0, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_MODE, MODE_ARMING, 3'd0, 2'd0, 16'h0, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_MODE, MODE_ARMING, 3'd0, 2'd0, 16'h0, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_MODE, MODE_ARMED, 3'd0, 2'd0, 16'h0, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_MIX, MODE_IDLE, 3'd0, 2'd0, 16'h0, 12'd0, 16'h8000, 16'h8000, 16'h8000));
    send(make_cmd(ACT_MIX, MODE_IDLE, 3'd0, 2'd0, 16'h0, 12'hfff, 16'h7fff, 16'h7fff,
                  16'h7fff));
    send(make_cmd(ACT_MIX, MODE_IDLE, 3'd0, 2'd0, 16'h0, 12'd1500, 16'h0001, 16'hffff,
                  16'hffff));
    send(make_cmd(ACT_MIX, MODE_IDLE, 3'd0, 2'd0, 16'h0, 12'd1500, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_MODE, MODE_IDLE, 3'd0, 2'd0, 16'h0, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_MIX, MODE_IDLE, 3'd0, 2'd0, 16'h0, 12'd1500, 16'h0100, 16'h0, 16'h0));
    send(make_cmd(ACT_MODE, MODE_ARMED, 3'd0, 2'd0, 16'h0, 12'd0, 16'h0, 16'h0, 16'h0));
    send(make_cmd(ACT_MIX, MODE_IDLE, 3'd0, 2'd0, 16'h0, 12'd1200, 16'hff00, 16'h0200,
                  16'h0040));
    run_phase(50);

    // Widest limits, arming pulse of zero, and no idling on either side.
    write_reg(CFG_PULSE_MIN, 12'd0);
    write_reg(CFG_PULSE_MAX, 12'hfff);
    write_reg(CFG_PULSE_ARM, 12'd0);
    stall_on = 1'b0;
    run_phase(60);
    stall_on = 1'b1;

    // Low bound above the high bound.
    write_reg(CFG_PULSE_MIN, 12'hfff);
    write_reg(CFG_PULSE_MAX, 12'd0);
    write_reg(CFG_PULSE_ARM, 12'hfff);
    write_reg(CFG_UNUSED, 12'ha5a);
    run_phase(60);

    // Arming pulse equal to the low bound.
    write_reg(CFG_PULSE_MIN, 12'd1100);
    write_reg(CFG_PULSE_MAX, 12'd1900);
    write_reg(CFG_PULSE_ARM, 12'd1100);
    run_phase(60);

    write_reg(CFG_PULSE_MIN, PULSE_W'($urandom_range(700, 1300)));
    write_reg(CFG_PULSE_MAX, PULSE_W'($urandom_range(1500, 2500)));
    write_reg(CFG_PULSE_ARM, PULSE_W'($urandom));
    run_phase(50);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_pulses.size() != 0) error_cnt++;
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
